>>> rtl/core/bclru_pkg.sv
// Package for the block cache LRU directory: item structs, status and kind codes,
// the sequencer state type and the entry tag layout.
// No dependencies.
`default_nettype none

package bclru_pkg;

   // request kinds
   localparam logic [1:0] KIND_FETCH = 2'd0;
   localparam logic [1:0] KIND_FILL  = 2'd1;
   localparam logic [1:0] KIND_STORE = 2'd2;

   // result status codes
   localparam logic [2:0] ST_HIT         = 3'd0;
   localparam logic [2:0] ST_MISS_ALLOC  = 3'd1;
   localparam logic [2:0] ST_RETRY_PEND  = 3'd2;
   localparam logic [2:0] ST_RETRY_NONE  = 3'd3;
   localparam logic [2:0] ST_STORE_HIT   = 3'd4;
   localparam logic [2:0] ST_STORE_ALLOC = 3'd5;
   localparam logic [2:0] ST_STORE_DROP  = 3'd6;
   localparam logic [2:0] ST_FILL_ACC    = 3'd7;

   localparam int STAMP_W = 64;
   localparam int LBA_W   = 64;
   localparam int DEV_W   = 4;
   localparam int WAY_W   = 7;

   typedef struct packed {
      logic [1:0]       kind;
      logic [DEV_W-1:0] device_id;
      logic [LBA_W-1:0] lba;
      logic [WAY_W-1:0] fill_way;
      logic             fill_ok;
   } req_type;

   typedef struct packed {
      logic [2:0]       status;
      logic [WAY_W-1:0] way;
   } rsp_type;

   // tag half of a directory entry
   typedef struct packed {
      logic [DEV_W-1:0] device_id;
      logic [LBA_W-1:0] lba;
   } tag_type;

   // outputs of the shared compare unit
   typedef struct packed {
      logic tag_eq;
      logic stamp_lt;
   } cmp_res_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_SCAN,
      SEQ_ACT,
      SEQ_RESP
   } seq_state_type;

endpackage

`default_nettype wire

>>> rtl/core/bclru_tag_ram.sv
// Directory storage: tag memory and stamp memory, one write port with separate
// enables and one registered read port. Depends on bclru_pkg.
`default_nettype none

module bclru_tag_ram
   import bclru_pkg::*;
#(
   parameter int ENTRIES = 128
) (
   input  wire logic                       clock,
   input  wire logic                       rd_en,
   input  wire logic [$clog2(ENTRIES)-1:0] rd_addr,
   output      tag_type                    rd_tag,
   output      logic [STAMP_W-1:0]         rd_stamp,
   input  wire logic                       tag_we,
   input  wire logic                       stamp_we,
   input  wire logic [$clog2(ENTRIES)-1:0] wr_addr,
   input  wire tag_type                    wr_tag,
   input  wire logic [STAMP_W-1:0]         wr_stamp
);

   tag_type            tag_mem   [ENTRIES];
   logic [STAMP_W-1:0] stamp_mem [ENTRIES];
   tag_type            rd_tag_ff;
   logic [STAMP_W-1:0] rd_stamp_ff;

   // write port
   always_ff @(posedge clock) begin
      if (tag_we) begin
         tag_mem[wr_addr] <= wr_tag;
      end
      if (stamp_we) begin
         stamp_mem[wr_addr] <= wr_stamp;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_tag_ff   <= tag_mem[rd_addr];
         rd_stamp_ff <= stamp_mem[rd_addr];
      end
   end

   assign rd_tag   = rd_tag_ff;
   assign rd_stamp = rd_stamp_ff;

endmodule

`default_nettype wire

>>> rtl/core/bclru_cmp.sv
// Shared compare unit: tag equality against the request and stamp ordering
// against the best LRU candidate so far. Depends on bclru_pkg.
`default_nettype none

module bclru_cmp
   import bclru_pkg::*;
(
   input  wire tag_type            entry_tag,
   input  wire logic [STAMP_W-1:0] entry_stamp,
   input  wire logic [DEV_W-1:0]   req_device,
   input  wire logic [LBA_W-1:0]   req_lba,
   input  wire logic [STAMP_W-1:0] best_stamp,
   output      cmp_res_type        res
);

   // one entry per cycle goes through here
   always_comb begin
      res.tag_eq   = (entry_tag.device_id == req_device) && (entry_tag.lba == req_lba);
      res.stamp_lt = entry_stamp < best_stamp;
   end

endmodule

`default_nettype wire

>>> rtl/core/block_cache_lru_directory_core.sv
// Tag directory of a fully associative block cache with LRU replacement.
// Fetch and store: the scan reads one entry per cycle through the single memory read
// port and runs to the last entry; a hit, or for a fetch a pending load, at entry k
// ends the scan early. Fill done and the unused kind skip the scan and go straight to
// the action step. One item at a time; a stall on rsp delays the next acceptance.
// Synchronous reset clears sequencer, valid and loading flags and the use counter;
// tag and stamp memories are not cleared (only entries flagged valid or loading are used).
`default_nettype none

module block_cache_lru_directory_core
   import bclru_pkg::*;
#(
   parameter int ENTRIES = 128
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output      logic    req_stall,
   input  wire req_type req_item,
   output      logic    rsp_valid,
   input  wire logic    rsp_stall,
   output      rsp_type rsp_item
);

   localparam int IDXW = $clog2(ENTRIES);
   localparam logic [IDXW-1:0] LAST_IDX = IDXW'(ENTRIES - 1);

   // low bits of an entry index for the way field
   function automatic logic [WAY_W-1:0] to_way(input logic [IDXW-1:0] idx);
      logic [31:0] w;
      w = 32'(idx);
      return w[WAY_W-1:0];
   endfunction

   seq_state_type      state_ff, state_in;
   req_type            req_ff, req_in;
   rsp_type            rsp_ff, rsp_in;
   logic [IDXW-1:0]    rd_idx_ff, rd_idx_in;
   logic [IDXW-1:0]    cmp_idx_ff, cmp_idx_in;
   logic               cmp_vld_ff, cmp_vld_in;
   logic               hit_ff, hit_in;
   logic               pend_ff, pend_in;
   logic [IDXW-1:0]    hit_idx_ff, hit_idx_in;
   logic               free_ff, free_in;
   logic [IDXW-1:0]    free_idx_ff, free_idx_in;
   logic               lru_ff, lru_in;
   logic [IDXW-1:0]    lru_idx_ff, lru_idx_in;
   logic [STAMP_W-1:0] lru_stamp_ff, lru_stamp_in;
   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [ENTRIES-1:0] loading_ff, loading_in;
   logic [STAMP_W-1:0] tick_ff, tick_in;

   logic               rd_en;
   tag_type            rd_tag;
   logic [STAMP_W-1:0] rd_stamp;
   logic               tag_we, stamp_we;
   logic [IDXW-1:0]    wr_addr;
   tag_type            wr_tag;
   logic [STAMP_W-1:0] tick_inc;
   cmp_res_type        cmp_res;

   logic               cur_valid, cur_loading;
   logic [31:0]        fill_way32;
   logic [IDXW-1:0]    fill_idx;
   logic               fill_live;
   logic               vic_found;
   logic [IDXW-1:0]    vic_idx;

   // directory memories
   bclru_tag_ram #(
      .ENTRIES (ENTRIES)
   ) u_ram (
      .clock    (clock),
      .rd_en    (rd_en),
      .rd_addr  (rd_idx_ff),
      .rd_tag   (rd_tag),
      .rd_stamp (rd_stamp),
      .tag_we   (tag_we),
      .stamp_we (stamp_we),
      .wr_addr  (wr_addr),
      .wr_tag   (wr_tag),
      .wr_stamp (tick_inc)
   );

   // shared compare unit
   bclru_cmp u_cmp (
      .entry_tag   (rd_tag),
      .entry_stamp (rd_stamp),
      .req_device  (req_ff.device_id),
      .req_lba     (req_ff.lba),
      .best_stamp  (lru_stamp_ff),
      .res         (cmp_res)
   );

   // helpers
   assign tick_inc    = tick_ff + 64'd1;
   assign rd_en       = (state_ff == SEQ_SCAN);
   assign wr_tag      = '{device_id: req_ff.device_id, lba: req_ff.lba};
   assign cur_valid   = valid_ff[cmp_idx_ff];
   assign cur_loading = loading_ff[cmp_idx_ff];
   assign fill_way32  = 32'(req_ff.fill_way);
   assign fill_idx    = fill_way32[IDXW-1:0];
   assign fill_live   = (fill_way32 < 32'(ENTRIES)) && loading_ff[fill_idx];
   assign vic_found   = free_ff || lru_ff;
   assign vic_idx     = free_ff ? free_idx_ff : lru_idx_ff;

   assign req_stall = (state_ff != SEQ_IDLE);
   assign rsp_valid = (state_ff == SEQ_RESP);
   assign rsp_item  = rsp_ff;

   // sequencer: next state and datapath control
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      rd_idx_in    = rd_idx_ff;
      cmp_idx_in   = cmp_idx_ff;
      cmp_vld_in   = 1'b0;
      hit_in       = hit_ff;
      pend_in      = pend_ff;
      hit_idx_in   = hit_idx_ff;
      free_in      = free_ff;
      free_idx_in  = free_idx_ff;
      lru_in       = lru_ff;
      lru_idx_in   = lru_idx_ff;
      lru_stamp_in = lru_stamp_ff;
      valid_in     = valid_ff;
      loading_in   = loading_ff;
      tick_in      = tick_ff;
      tag_we       = 1'b0;
      stamp_we     = 1'b0;
      wr_addr      = '0;

      unique case (state_ff)
         SEQ_IDLE: begin
            if (req_valid) begin
               req_in    = req_item;
               rd_idx_in = '0;
               hit_in    = 1'b0;
               pend_in   = 1'b0;
               free_in   = 1'b0;
               lru_in    = 1'b0;
               if ((req_item.kind == KIND_FETCH) || (req_item.kind == KIND_STORE)) begin
                  state_in = SEQ_SCAN;
               end else begin
                  state_in = SEQ_ACT;
               end
            end
         end

         // read entry i while entry i-1 goes through the compare unit
         SEQ_SCAN: begin
            rd_idx_in  = rd_idx_ff + 1'b1;
            cmp_idx_in = rd_idx_ff;
            cmp_vld_in = 1'b1;
            if (cmp_vld_ff) begin
               if (cur_valid && !cur_loading && cmp_res.tag_eq) begin
                  hit_in     = 1'b1;
                  hit_idx_in = cmp_idx_ff;
                  cmp_vld_in = 1'b0;
                  state_in   = SEQ_ACT;
               end else if (cur_loading && cmp_res.tag_eq && (req_ff.kind == KIND_FETCH)) begin
                  pend_in    = 1'b1;
                  cmp_vld_in = 1'b0;
                  state_in   = SEQ_ACT;
               end else begin
                  // first free entry
                  if (!cur_valid && !cur_loading && !free_ff) begin
                     free_in     = 1'b1;
                     free_idx_in = cmp_idx_ff;
                  end
                  // oldest valid entry, lowest index on a tie
                  if (cur_valid && !cur_loading && (!lru_ff || cmp_res.stamp_lt)) begin
                     lru_in       = 1'b1;
                     lru_idx_in   = cmp_idx_ff;
                     lru_stamp_in = rd_stamp;
                  end
                  if (cmp_idx_ff == LAST_IDX) begin
                     cmp_vld_in = 1'b0;
                     state_in   = SEQ_ACT;
                  end
               end
            end
         end

         // apply the decision and build the result item
         SEQ_ACT: begin
            state_in = SEQ_RESP;
            unique case (req_ff.kind)
               KIND_FETCH: begin
                  if (hit_ff) begin
                     stamp_we = 1'b1;
                     wr_addr  = hit_idx_ff;
                     tick_in  = tick_inc;
                     rsp_in   = '{status: ST_HIT, way: to_way(hit_idx_ff)};
                  end else if (pend_ff) begin
                     rsp_in = '{status: ST_RETRY_PEND, way: '0};
                  end else if (vic_found) begin
                     tag_we              = 1'b1;
                     wr_addr             = vic_idx;
                     loading_in[vic_idx] = 1'b1;
                     valid_in[vic_idx]   = 1'b0;
                     rsp_in = '{status: ST_MISS_ALLOC, way: to_way(vic_idx)};
                  end else begin
                     rsp_in = '{status: ST_RETRY_NONE, way: '0};
                  end
               end
               KIND_FILL: begin
                  if (fill_live) begin
                     loading_in[fill_idx] = 1'b0;
                     if (req_ff.fill_ok) begin
                        valid_in[fill_idx] = 1'b1;
                        stamp_we           = 1'b1;
                        wr_addr            = fill_idx;
                        tick_in            = tick_inc;
                     end
                     rsp_in = '{status: ST_FILL_ACC, way: req_ff.fill_way};
                  end else begin
                     rsp_in = '{status: ST_FILL_ACC, way: '0};
                  end
               end
               KIND_STORE: begin
                  if (hit_ff) begin
                     stamp_we = 1'b1;
                     wr_addr  = hit_idx_ff;
                     tick_in  = tick_inc;
                     rsp_in   = '{status: ST_STORE_HIT, way: to_way(hit_idx_ff)};
                  end else if (vic_found) begin
                     tag_we              = 1'b1;
                     stamp_we            = 1'b1;
                     wr_addr             = vic_idx;
                     valid_in[vic_idx]   = 1'b1;
                     loading_in[vic_idx] = 1'b0;
                     tick_in             = tick_inc;
                     rsp_in = '{status: ST_STORE_ALLOC, way: to_way(vic_idx)};
                  end else begin
                     rsp_in = '{status: ST_STORE_DROP, way: '0};
                  end
               end
               default: begin
                  // unused kind: directory left unchanged
                  rsp_in = '{status: ST_RETRY_NONE, way: '0};
               end
            endcase
         end

         SEQ_RESP: begin
            if (!rsp_stall) begin
               state_in = SEQ_IDLE;
            end
         end

         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= SEQ_IDLE;
         cmp_vld_ff <= 1'b0;
         valid_ff   <= '0;
         loading_ff <= '0;
         tick_ff    <= '0;
      end else begin
         state_ff   <= state_in;
         cmp_vld_ff <= cmp_vld_in;
         valid_ff   <= valid_in;
         loading_ff <= loading_in;
         tick_ff    <= tick_in;
      end
   end

   // scan bookkeeping and item registers
   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      rsp_ff       <= rsp_in;
      rd_idx_ff    <= rd_idx_in;
      cmp_idx_ff   <= cmp_idx_in;
      hit_ff       <= hit_in;
      pend_ff      <= pend_in;
      hit_idx_ff   <= hit_idx_in;
      free_ff      <= free_in;
      free_idx_ff  <= free_idx_in;
      lru_ff       <= lru_in;
      lru_idx_ff   <= lru_idx_in;
      lru_stamp_ff <= lru_stamp_in;
   end

endmodule

`default_nettype wire
